FILE: sv/atoi_pkg.sv
// shared types, constants and helper functions for the ascii to signed integer converter
`default_nettype none

package atoi_pkg;

	// saturation limit of the position counters
	localparam logic [11:0] POS_CAP = 12'd4095;

	// largest and smallest radix accepted, and the fixed radix values
	localparam logic [5:0] BASE_MAX  = 6'd36;
	localparam logic [5:0] BASE_MIN  = 6'd2;
	localparam logic [5:0] BASE_OCT  = 6'd8;
	localparam logic [5:0] BASE_DEC  = 6'd10;
	localparam logic [5:0] BASE_HEX  = 6'd16;
	localparam logic [5:0] BASE_AUTO = 6'd0;

	// digit value marking a byte that is no digit at all
	localparam logic [5:0] NOT_DIGIT = 6'd63;

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_LO_Z  = 8'h7a;

	// letter offsets: 'A' - 10 and 'a' - 10
	localparam logic [7:0] UP_OFS = 8'd55;
	localparam logic [7:0] LO_OFS = 8'd87;

	// magnitude limits for positive and negative results
	localparam logic [63:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

	// parse phase
	typedef enum logic [2:0] {
		PH_BLANK  = 3'd0,
		PH_FIRST  = 3'd1,
		PH_ZERO   = 3'd2,
		PH_XSEEN  = 3'd3,
		PH_DIGITS = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	// value of a digit or letter, NOT_DIGIT for anything else
	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [5:0] d;
		d = NOT_DIGIT;
		if (c inside {[CH_0:CH_9]}) begin
			d = 6'(c - CH_0);
		end else if (c inside {[CH_UP_A:CH_UP_Z]}) begin
			d = 6'(c - UP_OFS);
		end else if (c inside {[CH_LO_A:CH_LO_Z]}) begin
			d = 6'(c - LO_OFS);
		end
		return d;
	endfunction

	// space, tab, line feed, vertical tab, form feed, carriage return
	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

	// saturating position increment
	function automatic logic [11:0] next_pos(input logic [11:0] p);
		return (p < POS_CAP) ? 12'(p + 12'd1) : POS_CAP;
	endfunction

endpackage

`default_nettype wire

FILE: sv/ascii_to_signed_integer.sv
// streaming ascii to signed 64-bit integer converter, top level
`default_nettype none

// Takes one string byte per transaction on the input channel and gives one
// result on the byte marked end_of_string. Leading blanks are skipped, an
// optional sign is taken, and for radix 0 or 16 a 0x / 0X prefix is used only
// when a hex digit follows; radix 0 becomes 8 after a leading zero, else 10.
// Out-of-range values saturate and raise overflowed; an invalid radix gives no
// conversion. number_base is sampled on the first byte after blanks and sign,
// so write it only between strings. Throughput is one byte per clock while
// the input is not stalled. An accepted byte is held in the input register
// and then folded into the state registers, and the result of a marked byte
// is registered at that same edge, from where it is offered. A result still
// waiting for out_ready stalls the input only once the next marked byte
// reaches the state stage. The clock rate is bounded by the 64 x 6 bit
// multiply, digit add and limit compare in the state update stage.
module ascii_to_signed_integer
	import atoi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	// configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  number_base,

	// byte input
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	input  wire logic        end_of_string,

	// result output
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [63:0] parsed_value,
	output logic [11:0]      chars_consumed,
	output logic             converted,
	output logic             overflowed
);

	// configuration register
	logic [5:0] base_cfg_q;

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// parser state
	phase_t      phase_q, phase_d;
	logic [63:0] acc_q, acc_d;
	logic        neg_q, neg_d;
	logic        saw_q, saw_d;
	logic        ovf_q, ovf_d;
	logic [5:0]  abase_q, abase_d;
	logic [11:0] pos_q;
	logic [11:0] endpos_q, endpos_d;

	// result register
	logic        res_valid_q;
	logic [63:0] res_acc_q;
	logic        res_neg_q;
	logic        res_saw_q;
	logic        res_ovf_q;
	logic [11:0] res_endpos_q;

	// decode strobes
	logic        proc;
	logic        take;
	logic [5:0]  tdig;
	logic [5:0]  tbase;
	logic        set_neg;
	logic        do_first;

	// first byte decode
	logic [5:0]  dig;
	logic        fc_zero;
	logic [5:0]  fc_base;
	logic        fc_bad;

	// multiply-add and limit check
	logic [69:0] prod;
	logic [63:0] cutoff;
	logic        too_big;

	// handshakes
	assign cfg_ready = 1'b1;
	assign proc      = valid_s1 && (!last_s1 || !res_valid_q || out_ready);
	assign in_ready  = !valid_s1 || proc;

	// configuration register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_cfg_q <= BASE_AUTO;
		end else if (cfg_valid && cfg_ready) begin
			base_cfg_q <= number_base;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= end_of_string;
		end
	end

	// byte classification
	assign dig     = digit_of(char_s1);
	assign fc_zero = ((base_cfg_q == BASE_AUTO) || (base_cfg_q == BASE_HEX)) &&
	                 (char_s1 == CH_0);
	assign fc_base = (base_cfg_q == BASE_AUTO) ? BASE_DEC : base_cfg_q;
	assign fc_bad  = (fc_base < BASE_MIN) || (fc_base > BASE_MAX);

	// next phase and digit strobes
	always_comb begin
		phase_d  = phase_q;
		take     = 1'b0;
		tdig     = 6'd0;
		tbase    = abase_q;
		set_neg  = 1'b0;
		do_first = 1'b0;
		case (phase_q)
			PH_BLANK: begin
				if (!is_blank(char_s1)) begin
					if (char_s1 == CH_MINUS) begin
						set_neg = 1'b1;
						phase_d = PH_FIRST;
					end else if (char_s1 == CH_PLUS) begin
						phase_d = PH_FIRST;
					end else begin
						do_first = 1'b1;
					end
				end
			end
			PH_FIRST: begin
				do_first = 1'b1;
			end
			PH_ZERO: begin
				if ((char_s1 == CH_LO_X) || (char_s1 == CH_UP_X)) begin
					phase_d = PH_XSEEN;
				end else if (dig < abase_q) begin
					take    = 1'b1;
					tdig    = dig;
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_XSEEN: begin
				if (dig < BASE_HEX) begin
					take    = 1'b1;
					tdig    = dig;
					tbase   = BASE_HEX;
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (dig < abase_q) begin
					take    = 1'b1;
					tdig    = dig;
				end else begin
					phase_d = PH_DONE;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		// first byte after blanks and sign picks the radix
		if (do_first) begin
			if (fc_zero) begin
				take    = 1'b1;
				tdig    = 6'd0;
				tbase   = (base_cfg_q == BASE_AUTO) ? BASE_OCT : BASE_HEX;
				phase_d = PH_ZERO;
			end else if (fc_bad) begin
				phase_d = PH_DONE;
			end else if (dig < fc_base) begin
				take    = 1'b1;
				tdig    = dig;
				tbase   = fc_base;
				phase_d = PH_DIGITS;
			end else begin
				phase_d = PH_DONE;
			end
		end
	end

	// multiply-add, exact overflow test against the signed limit
	assign prod    = 70'(acc_q) * 70'(tbase) + 70'(tdig);
	assign cutoff  = neg_d ? NEG_LIMIT : POS_LIMIT;
	assign too_big = prod > 70'(cutoff);

	// datapath update
	always_comb begin
		neg_d    = neg_q || set_neg;
		acc_d    = acc_q;
		saw_d    = saw_q;
		ovf_d    = ovf_q;
		abase_d  = abase_q;
		endpos_d = endpos_q;
		if (take) begin
			abase_d  = tbase;
			saw_d    = 1'b1;
			endpos_d = next_pos(pos_q);
			if (ovf_q || too_big) begin
				ovf_d = 1'b1;
			end else begin
				acc_d = prod[63:0];
			end
		end
	end

	// parser state registers, cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BLANK;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			saw_q    <= 1'b0;
			ovf_q    <= 1'b0;
			abase_q  <= 6'd0;
			pos_q    <= 12'd0;
			endpos_q <= 12'd0;
		end else if (proc) begin
			if (last_s1) begin
				phase_q  <= PH_BLANK;
				acc_q    <= '0;
				neg_q    <= 1'b0;
				saw_q    <= 1'b0;
				ovf_q    <= 1'b0;
				abase_q  <= 6'd0;
				pos_q    <= 12'd0;
				endpos_q <= 12'd0;
			end else begin
				phase_q  <= phase_d;
				acc_q    <= acc_d;
				neg_q    <= neg_d;
				saw_q    <= saw_d;
				ovf_q    <= ovf_d;
				abase_q  <= abase_d;
				pos_q    <= next_pos(pos_q);
				endpos_q <= endpos_d;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			res_acc_q    <= acc_d;
			res_neg_q    <= neg_d;
			res_saw_q    <= saw_d;
			res_ovf_q    <= ovf_d;
			res_endpos_q <= endpos_d;
		end
	end

	// result formatting: saturation, sign and no-conversion cases
	always_comb begin
		if (res_ovf_q) begin
			parsed_value = res_neg_q ? NEG_LIMIT : POS_LIMIT;
		end else if (res_saw_q) begin
			parsed_value = res_neg_q ? (64'd0 - res_acc_q) : res_acc_q;
		end else begin
			parsed_value = '0;
		end
	end

	assign out_valid      = res_valid_q;
	assign chars_consumed = res_saw_q ? res_endpos_q : 12'd0;
	assign converted      = res_saw_q;
	assign overflowed     = res_ovf_q;

endmodule

`default_nettype wire
